[rtl/core/pru_pkg.sv]
`timescale 1ns / 1ps

package pru_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam int CFG_DATA_W = 16;
  localparam int PIX_W      = 24;

  // flags that travel with a pixel read through the row store
  typedef struct packed {
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       frame_end;
    logic       overrun;
  } pix_meta_t;

endpackage

[rtl/core/pixel_replicate_upscaler.sv]
`timescale 1ns / 1ps

// Nearest-neighbor integer upscaler for 24-bit pixels. Load items (kind 0) fill a
// row store of MAX_WIDTH entries; once a whole source row is in, each request item
// (kind 1) returns the next output pixel, every source pixel repeated scale_factor
// times across and the row replayed scale_factor times down. The block takes one
// item per clock while in_stall is low. An accepted request's pixel goes through
// the row store's synchronous read and then the output register. The input stalls
// only while both the read stage and the output register hold a pixel and the
// output is stalled. Loads and reads of the store never overlap (loads happen
// only while no row is ready, reads only while one is), so no forwarding is
// needed. The row store is not cleared after reset. Configuration is written
// via the cfg_ port (always ready), by the user only while idle (not enforced).
module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 100
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_red,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_red,
  output logic                            out_row_end,
  output logic [1:0]                      out_pad_bytes,
  output logic                            out_frame_end,
  output logic                            out_overrun,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = (CW > 13) ? CW : 13;
  localparam int SW  = $clog2(MAX_SCALE + 1);
  localparam int SXW = (SW > 7) ? SW : 7;

  // configuration
  logic [6:0]  scale_r;
  logic [12:0] width_r;
  logic [15:0] height_r;

  // replay state
  logic [AW-1:0] load_pos_r, load_pos_nxt;
  logic          row_ready_r, row_ready_nxt;
  logic [AW-1:0] src_col_r, src_col_nxt;
  logic [SW-1:0] col_rep_r, col_rep_nxt;
  logic [SW-1:0] row_rep_r, row_rep_nxt;
  logic [15:0]   rows_done_r, rows_done_nxt;
  logic          ovr_pend_r, ovr_pend_nxt;

  // pipeline
  logic                s1_valid_r, s1_valid_nxt;
  pru_pkg::pix_meta_t  s1_meta_r, s1_meta_nxt;
  logic                out_valid_r, out_valid_nxt;
  pru_pkg::pix_meta_t  out_meta_r;
  logic [pru_pkg::PIX_W-1:0] out_pix_r;

  // row store
  logic [pru_pkg::PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [pru_pkg::PIX_W-1:0] rd_data_r;
  logic                      mem_we;
  logic                      mem_re;

  logic in_xfer;
  logic s1_move;
  logic emit;

  // effective configuration
  logic [XW-1:0]  w_clamp;
  logic [SXW-1:0] s_clamp;
  logic [CW-1:0]  eff_w;
  logic [SW-1:0]  eff_s;
  logic [15:0]    eff_h;
  logic [3:0]     pad_prod;

  logic [CW-1:0] load_inc;
  logic [CW-1:0] col_inc;
  logic [SW-1:0] col_rep_inc;
  logic [SW-1:0] row_rep_inc;
  logic [16:0]   rows_inc;
  logic          col_wrap;
  logic          last_col;
  logic          last_rep;
  logic          last_frame;

  always_comb begin
    w_clamp = XW'(width_r);
    if (w_clamp == '0) begin
      w_clamp = XW'(1);
    end else if (w_clamp > XW'(MAX_WIDTH)) begin
      w_clamp = XW'(MAX_WIDTH);
    end
    s_clamp = SXW'(scale_r);
    if (s_clamp == '0) begin
      s_clamp = SXW'(1);
    end else if (s_clamp > SXW'(MAX_SCALE)) begin
      s_clamp = SXW'(MAX_SCALE);
    end
  end

  assign eff_w = CW'(w_clamp);
  assign eff_s = SW'(s_clamp);
  assign eff_h = (height_r == 16'd0) ? 16'd1 : height_r;
  // (-3*w*s) mod 4 equals (w*s) mod 4
  assign pad_prod = {2'b00, w_clamp[1:0]} * {2'b00, s_clamp[1:0]};

  assign load_inc    = CW'(load_pos_r) + CW'(1);
  assign col_inc     = CW'(src_col_r) + CW'(1);
  assign col_rep_inc = col_rep_r + SW'(1);
  assign row_rep_inc = row_rep_r + SW'(1);
  assign rows_inc    = {1'b0, rows_done_r} + 17'd1;

  assign col_wrap   = col_rep_inc >= eff_s;
  assign last_col   = col_wrap && (col_inc >= eff_w);
  assign last_rep   = row_rep_inc >= eff_s;
  assign last_frame = last_col && last_rep && (rows_inc >= {1'b0, eff_h});

  // handshake
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign emit     = in_xfer && (in_kind == pru_pkg::KIND_REQUEST) && row_ready_r;
  assign mem_we   = in_xfer && (in_kind == pru_pkg::KIND_LOAD) && !row_ready_r;
  assign mem_re   = emit;

  always_comb begin
    load_pos_nxt  = load_pos_r;
    row_ready_nxt = row_ready_r;
    src_col_nxt   = src_col_r;
    col_rep_nxt   = col_rep_r;
    row_rep_nxt   = row_rep_r;
    rows_done_nxt = rows_done_r;
    ovr_pend_nxt  = ovr_pend_r;

    if (in_xfer && (in_kind == pru_pkg::KIND_LOAD)) begin
      if (row_ready_r) begin
        ovr_pend_nxt = 1'b1;
      end else if (load_inc >= eff_w) begin
        load_pos_nxt  = '0;
        row_ready_nxt = 1'b1;
      end else begin
        load_pos_nxt = AW'(load_inc);
      end
    end

    if (emit) begin
      ovr_pend_nxt = 1'b0;
      col_rep_nxt  = col_rep_inc;
      if (col_wrap) begin
        col_rep_nxt = '0;
        src_col_nxt = AW'(col_inc);
        if (col_inc >= eff_w) begin
          src_col_nxt = '0;
          row_rep_nxt = row_rep_inc;
          if (last_rep) begin
            row_rep_nxt   = '0;
            row_ready_nxt = 1'b0;
            rows_done_nxt = last_frame ? 16'd0 : rows_inc[15:0];
          end
        end
      end
    end
  end

  always_comb begin
    s1_meta_nxt.row_end   = last_col;
    s1_meta_nxt.pad_bytes = last_col ? pad_prod[1:0] : 2'd0;
    s1_meta_nxt.frame_end = last_frame;
    s1_meta_nxt.overrun   = ovr_pend_r;
    s1_valid_nxt  = emit || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 7'd1;
      width_r  <= 13'd1;
      height_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pru_pkg::CFG_SCALE:  scale_r  <= cfg_data[6:0];
        pru_pkg::CFG_WIDTH:  width_r  <= cfg_data[12:0];
        pru_pkg::CFG_HEIGHT: height_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r  <= '0;
      row_ready_r <= 1'b0;
      src_col_r   <= '0;
      col_rep_r   <= '0;
      row_rep_r   <= '0;
      rows_done_r <= '0;
      ovr_pend_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      load_pos_r  <= load_pos_nxt;
      row_ready_r <= row_ready_nxt;
      src_col_r   <= src_col_nxt;
      col_rep_r   <= col_rep_nxt;
      row_rep_r   <= row_rep_nxt;
      rows_done_r <= rows_done_nxt;
      ovr_pend_r  <= ovr_pend_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      s1_meta_r <= s1_meta_nxt;
    end
    if (s1_move) begin
      out_pix_r  <= rd_data_r;
      out_meta_r <= s1_meta_r;
    end
  end

  // row store, read data holds while the read stage is blocked
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[load_pos_r] <= {in_red, in_green, in_blue};
    end
    if (mem_re) begin
      rd_data_r <= row_mem[src_col_r];
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_blue      = out_pix_r[7:0];
  assign out_green     = out_pix_r[15:8];
  assign out_red       = out_pix_r[23:16];
  assign out_row_end   = out_meta_r.row_end;
  assign out_pad_bytes = out_meta_r.pad_bytes;
  assign out_frame_end = out_meta_r.frame_end;
  assign out_overrun   = out_meta_r.overrun;

`ifndef SYNTHESIS
  a_no_load_during_replay: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("row store written and read in the same cycle");

  a_s1_holds_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("read stage lost a pixel while output stalled");

  a_pad_only_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_end || (out_pad_bytes == 2'd0)))
    else $error("pad bytes reported away from row end");

  a_frame_end_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end) |-> out_row_end)
    else $error("frame end not on a row end");

  a_row_done_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_col && last_rep) |=> !row_ready_r)
    else $error("row still ready after its last replay");
`endif

endmodule
